// File: rtl/dqs_pkg.sv
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types and codes for the byte deque with search.
// ----------------------------------------------------------------------------
package dqs_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_LOAD = 3'd1,
    CELL_SHR  = 3'd2,
    CELL_SHL  = 3'd3,
    CELL_ROT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] letter;
  } cell_ctl_t;

endpackage

// File: rtl/dqs_cell.sv
// ----------------------------------------------------------------------------
// dqs_cell
// One byte slot of the deque chain; slot IDX holds the entry at that
// distance from the front.
// ----------------------------------------------------------------------------
module dqs_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic              clk,
  input  dqs_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]     count,
  input  logic [7:0]        from_left,
  input  logic [7:0]        from_right,
  input  logic [7:0]        from_front,
  output logic [7:0]        q
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;
  logic       at_tail;
  logic       is_last;

  assign at_tail = (count == CW'(IDX));
  assign is_last = (count == CW'(IDX + 1));

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      dqs_pkg::CELL_LOAD: begin
        if (at_tail) data_nxt = ctl.letter;
      end
      dqs_pkg::CELL_SHR:  data_nxt = from_left;
      dqs_pkg::CELL_SHL:  data_nxt = from_right;
      dqs_pkg::CELL_ROT:  data_nxt = is_last ? from_front : from_right;
      default:            data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// File: rtl/deque_with_search_core.sv
// ----------------------------------------------------------------------------
// deque_with_search_core
// Bounded byte deque built as a shift chain of cells, with front search.
// ----------------------------------------------------------------------------
// Entries sit in a chain of DEPTH cells, the front entry in cell 0. Append,
// insert-front, remove-front, clear, unused codes and a search of an empty
// deque give their result on the next edge. A search rotates the occupied
// part of the chain by one cell per cycle past a single comparator at the
// front, and gives its result once every held entry has passed the front;
// the chain is back in its original order when it ends. One request is in
// flight at a time, and a new one is taken while the previous result is
// being handed off.
module deque_with_search_core #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] operation, [10:3] letter, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] removed_letter, [9:8] status,
                                  // [16:10] position, [23:17] occupancy
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            found_r, found_nxt;
  logic [7:0]      letter_r, letter_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      removed_r, removed_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [CW-1:0]   opos_r, opos_nxt;
  logic [CW-1:0]   occ_r, occ_nxt;

  logic [2:0]      in_op;
  logic [7:0]      in_letter;
  logic            in_accept;
  logic            full;
  logic            empty;
  logic            hit;
  dqs_pkg::cell_ctl_t ctl;
  logic [7:0]      q [DEPTH];
  logic [CW+6:0]   opos_ext;
  logic [CW+6:0]   occ_ext;

  assign in_op     = in_tdata[2:0];
  assign in_letter = in_tdata[10:3];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign hit       = (q[0] == letter_r) && !found_r;

  always_comb begin
    ctl.letter = in_letter;
    ctl.op     = dqs_pkg::CELL_HOLD;
    if (state_r == S_SEARCH) begin
      ctl.op = dqs_pkg::CELL_ROT;
    end else if (in_accept) begin
      case (in_op)
        dqs_pkg::OP_APPEND: if (!full)  ctl.op = dqs_pkg::CELL_LOAD;
        dqs_pkg::OP_INSERT: if (!full)  ctl.op = dqs_pkg::CELL_SHR;
        dqs_pkg::OP_REMOVE: if (!empty) ctl.op = dqs_pkg::CELL_SHL;
        default:            ctl.op = dqs_pkg::CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dqs_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .from_left  ((i == 0) ? in_letter : q[(i + DEPTH - 1) % DEPTH]),
      .from_right (q[(i + 1) % DEPTH]),
      .from_front (q[0]),
      .q          (q[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    pos_nxt       = pos_r;
    found_nxt     = found_r;
    letter_nxt    = letter_r;
    out_valid_nxt = out_valid_r && !out_tready;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    opos_nxt      = opos_r;
    occ_nxt       = occ_r;

    if (state_r == S_SEARCH) begin
      k_nxt = k_r + 1'b1;
      if (hit) begin
        found_nxt = 1'b1;
        pos_nxt   = k_r + 1'b1;
      end
      if (k_r + 1'b1 == count_r) begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        removed_nxt   = '0;
        status_nxt    = (found_r || hit) ? dqs_pkg::ST_OK : dqs_pkg::ST_NOTFOUND;
        opos_nxt      = hit ? k_r + 1'b1 : pos_r;
        occ_nxt       = count_r;
      end
    end else if (in_accept) begin
      out_valid_nxt = 1'b1;
      removed_nxt   = '0;
      status_nxt    = dqs_pkg::ST_OK;
      opos_nxt      = '0;
      case (in_op)
        dqs_pkg::OP_APPEND, dqs_pkg::OP_INSERT: begin
          if (full) status_nxt = dqs_pkg::ST_FULL;
          else      count_nxt  = count_r + 1'b1;
        end
        dqs_pkg::OP_REMOVE: begin
          if (empty) begin
            status_nxt = dqs_pkg::ST_EMPTY;
          end else begin
            removed_nxt = q[0];
            count_nxt   = count_r - 1'b1;
          end
        end
        dqs_pkg::OP_SEARCH: begin
          if (empty) begin
            status_nxt = dqs_pkg::ST_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_SEARCH;
            k_nxt         = '0;
            pos_nxt       = '0;
            found_nxt     = 1'b0;
            letter_nxt    = in_letter;
          end
        end
        dqs_pkg::OP_CLEAR: count_nxt = '0;
        default:           count_nxt = count_r;
      endcase
      occ_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    pos_r     <= pos_nxt;
    found_r   <= found_nxt;
    letter_r  <= letter_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    opos_r    <= opos_nxt;
    occ_r     <= occ_nxt;
  end

  assign opos_ext   = {7'd0, opos_r};
  assign occ_ext    = {7'd0, occ_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {occ_ext[6:0], opos_ext[6:0], status_r, removed_r};

endmodule

// File: rtl/dqs_checker.sv
// ----------------------------------------------------------------------------
// dqs_checker
// Port-level checks for the byte deque with search.
// ----------------------------------------------------------------------------
module dqs_checker #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  logic [7:0] removed;
  logic [1:0] status;
  logic [6:0] position;
  logic [6:0] occupancy;

  assign removed   = out_tdata[7:0];
  assign status    = out_tdata[9:8];
  assign position  = out_tdata[16:10];
  assign occupancy = out_tdata[23:17];

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == dqs_pkg::ST_FULL |->
      (DEPTH > 127) || occupancy == 7'(DEPTH))
    else $error("full status with room left");

  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && removed != 8'd0 |-> status == dqs_pkg::ST_OK && position == 7'd0)
    else $error("removed byte on failed request");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && position != 7'd0 |->
      status == dqs_pkg::ST_OK && ((DEPTH > 127) || position <= occupancy))
    else $error("search position out of range");

  logic unused_in;
  assign unused_in = in_tvalid & in_tready & ^in_tdata;

endmodule

bind deque_with_search_core dqs_checker #(.DEPTH(DEPTH)) u_dqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
